[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ubxpe_pkg.sv]
package ubxpe_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_WANTED_CLASS   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WANTED_MESSAGE = 1'b1;

  localparam logic [7:0] WANTED_CLASS_RESET   = 8'd1;
  localparam logic [7:0] WANTED_MESSAGE_RESET = 8'd7;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_CLASS,
    PH_MESSAGE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic        has_data;
    logic        last;
  } out_word_t;

endpackage

[hdl/ubx_payload_extractor.sv]
// Binary frame payload extractor. Takes one serial byte per word on the rx side, hunts for
// the sync pair B5 62, checks class and message id against wanted_class (register 0) and
// wanted_message (register 1), reads a little-endian 16-bit length and then hands out each
// payload byte with its index, the announced length and a last mark on the final byte. A
// zero length gives one word with has_data low and last high. The checksum is not checked.
// One byte is taken every cycle while in_stall is low; a byte moves through an input register
// and then into the result register, from which it leaves when out_stall is low. A two-entry
// result buffer keeps the input open while one result waits on out_stall; in_stall rises only
// when both entries are held.
module ubx_payload_extractor
  import ubxpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             payload_byte,
  output logic [15:0]            byte_index,
  output logic [15:0]            frame_length,
  output logic                   has_data,
  output logic                   last
);

  logic      byte_valid;
  logic [7:0] byte_reg;
  logic      res_ready;
  logic      step;
  logic      push;
  out_word_t push_word;
  out_word_t out_word;

  assign step     = byte_valid && res_ready;
  assign in_stall = byte_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_reg <= rx_byte;
    end
  end

  ubxpe_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .rx_byte   (byte_reg),
    .push      (push),
    .word      (push_word)
  );

  ubxpe_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (push && step),
    .push_word (push_word),
    .ready     (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign payload_byte = out_word.payload_byte;
  assign byte_index   = out_word.byte_index;
  assign frame_length = out_word.frame_length;
  assign has_data     = out_word.has_data;
  assign last         = out_word.last;

endmodule

[hdl/ubxpe_parser.sv]
module ubxpe_parser
  import ubxpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output logic                   push,
  output out_word_t              word
);

  logic [7:0]  wanted_class;
  logic [7:0]  wanted_message;
  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] announced_length;
  logic [15:0] announced_length_next;
  logic [15:0] bytes_seen;
  logic [15:0] bytes_seen_next;
  logic        fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_class   <= WANTED_CLASS_RESET;
      wanted_message <= WANTED_MESSAGE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WANTED_CLASS:   wanted_class   <= cfg_data;
        REG_WANTED_MESSAGE: wanted_message <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      announced_length <= '0;
      bytes_seen       <= '0;
    end else if (step) begin
      phase            <= phase_next;
      announced_length <= announced_length_next;
      bytes_seen       <= bytes_seen_next;
    end
  end

  assign fin = (({1'b0, bytes_seen} + 17'd1) == {1'b0, announced_length});

  always_comb begin
    phase_next            = PH_HUNT;
    announced_length_next = announced_length;
    bytes_seen_next       = bytes_seen;
    push                  = 1'b0;
    word                  = '0;
    unique case (phase)
      PH_HUNT: begin
        phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      end
      PH_SYNC2: begin
        phase_next = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
      end
      PH_CLASS: begin
        phase_next = (rx_byte == wanted_class) ? PH_MESSAGE : PH_HUNT;
      end
      PH_MESSAGE: begin
        phase_next = (rx_byte == wanted_message) ? PH_LEN_LO : PH_HUNT;
      end
      PH_LEN_LO: begin
        announced_length_next = {8'd0, rx_byte};
        phase_next            = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        announced_length_next = {rx_byte, announced_length[7:0]};
        bytes_seen_next       = '0;
        if (announced_length_next == 16'd0) begin
          // empty payload closes the frame right away
          phase_next = PH_HUNT;
          push       = 1'b1;
          word.last  = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        bytes_seen_next   = bytes_seen + 16'd1;
        phase_next        = fin ? PH_HUNT : PH_PAYLOAD;
        push              = 1'b1;
        word.payload_byte = rx_byte;
        word.byte_index   = bytes_seen;
        word.frame_length = announced_length;
        word.has_data     = 1'b1;
        word.last         = fin;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

endmodule

[hdl/ubxpe_out_reg.sv]
module ubxpe_out_reg
  import ubxpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_word_t push_word,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  out_word_t skid_word;
  logic      skid_valid;
  logic      pop;

  assign ready = !skid_valid;
  assign pop   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_word <= skid_valid ? skid_word : push_word;
    end else if (push && !skid_valid) begin
      skid_word <= push_word;
    end
  end

endmodule

[hdl/ubxpe_checker.sv]
`include "assert_macros.svh"

module ubxpe_checker
  import ubxpe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  payload_byte,
  input logic [15:0] byte_index,
  input logic [15:0] frame_length,
  input logic        has_data,
  input logic        last
);

  `ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "result valid right after reset")

  `ASSERT_ON_CLK(a_held_word, out_valid && out_stall |=> out_valid && $stable(byte_index), "stalled word dropped or changed")

  `ASSERT_ON_CLK(a_empty_frame, out_valid && !has_data |-> last && payload_byte == 8'd0 && byte_index == 16'd0 && frame_length == 16'd0, "bad empty frame word")

  `ASSERT_ON_CLK(a_index_range, out_valid && has_data |-> byte_index < frame_length && (last == (byte_index + 17'd1 == {1'b0, frame_length})), "index or last mark out of line with length")

endmodule

bind ubx_payload_extractor ubxpe_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .payload_byte (payload_byte),
  .byte_index   (byte_index),
  .frame_length (frame_length),
  .has_data     (has_data),
  .last         (last)
);

[bench/ubx_payload_extractor_check.sv]
module ubx_payload_extractor_check
  import ubxpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             rx_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [7:0]             payload_byte,
  input  logic [15:0]            byte_index,
  input  logic [15:0]            frame_length,
  input  logic                   has_data,
  input  logic                   last,
  output int                     errors,
  output int                     pending
);

  phase_t      phase;
  logic [15:0] length_q;
  logic [15:0] seen_q;
  logic [7:0]  want_class;
  logic [7:0]  want_msg;
  out_word_t   expected_words[$];

  function automatic bit parse_byte(input logic [7:0] b, output out_word_t w);
    w = '0;
    parse_byte = 1'b0;
    case (phase)
      PH_HUNT: phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      PH_SYNC2: phase = (b == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
      PH_CLASS: phase = (b == want_class) ? PH_MESSAGE : PH_HUNT;
      PH_MESSAGE: phase = (b == want_msg) ? PH_LEN_LO : PH_HUNT;
      PH_LEN_LO: begin
        length_q = {8'h00, b};
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_q = {b, length_q[7:0]};
        seen_q = '0;
        if (length_q == 16'd0) begin
          // empty payload: one marker word
          w.last = 1'b1;
          parse_byte = 1'b1;
          phase = PH_HUNT;
        end else begin
          phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        w.payload_byte = b;
        w.byte_index = seen_q;
        w.frame_length = length_q;
        w.has_data = 1'b1;
        w.last = ({1'b0, seen_q} + 17'd1) == {1'b0, length_q};
        seen_q = seen_q + 16'd1;
        if (w.last) phase = PH_HUNT;
        parse_byte = 1'b1;
      end
      default: phase = PH_HUNT;
    endcase
  endfunction

  function automatic int field_bad(input string name, input logic [15:0] want,
                                   input logic [15:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : track
    out_word_t made;
    out_word_t got;
    out_word_t want;
    int bad;
    bit pushed;
    bit popped;
    if (rst) begin
      phase = PH_HUNT;
      length_q = '0;
      seen_q = '0;
      want_class = WANTED_CLASS_RESET;
      want_msg = WANTED_MESSAGE_RESET;
      expected_words.delete();
      pending <= 0;
      errors <= 0;
    end else begin
      bad = 0;
      pushed = 1'b0;
      popped = 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          REG_WANTED_CLASS: want_class = cfg_data;
          REG_WANTED_MESSAGE: want_msg = cfg_data;
          default: ;
        endcase
      end
      // retire before predicting, so a word never matches a byte taken at the same edge
      if (out_valid && !out_stall) begin
        got = {payload_byte, byte_index, frame_length, has_data, last};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none got byte %0h index %0h length %0h",
                   $time, got.payload_byte, got.byte_index, got.frame_length,
                   " has_data %0b last %0b", got.has_data, got.last);
          bad = bad + 1;
        end else begin
          want = expected_words.pop_front();
          popped = 1'b1;
          bad = bad + field_bad("payload_byte", want.payload_byte, got.payload_byte);
          bad = bad + field_bad("byte_index", want.byte_index, got.byte_index);
          bad = bad + field_bad("frame_length", want.frame_length, got.frame_length);
          bad = bad + field_bad("has_data", want.has_data, got.has_data);
          bad = bad + field_bad("last", want.last, got.last);
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(rx_byte, made)) begin
          expected_words.push_back(made);
          pushed = 1'b1;
        end
      end
      pending <= pending + pushed - popped;
      errors <= errors + bad;
    end
  end

endmodule

[bench/ubx_payload_extractor_test.sv]
module ubx_payload_extractor_test;
  import ubxpe_pkg::*;

  localparam int LATENCY = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 950;
  localparam int PHASES = 5;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             rx_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             payload_byte;
  logic [15:0]            byte_index;
  logic [15:0]            frame_length;
  logic                   has_data;
  logic                   last;

  int         errors;
  int         pending;
  int         items_sent;
  int         quiet_cycles;
  bit         in_quiet;
  logic [7:0] cur_class;
  logic [7:0] cur_msg;

  ubx_payload_extractor dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .payload_byte(payload_byte),
    .byte_index(byte_index),
    .frame_length(frame_length),
    .has_data(has_data),
    .last(last)
  );

  ubx_payload_extractor_check frame_check (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .payload_byte(payload_byte),
    .byte_index(byte_index),
    .frame_length(frame_length),
    .has_data(has_data),
    .last(last),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte(input int lo = 0, input int hi = 255);
    rand_byte = 8'($urandom_range(hi, lo));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return 0;
    if (r < 70) return $urandom_range(8, 1);
    if (r < 96) return $urandom_range(40, 9);
    return $urandom_range(300, 256);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  task automatic send_header(input logic [7:0] cls, input logic [7:0] msg,
                             input logic [15:0] len);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cls);
    send_byte(msg);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  task automatic send_payload(input int n);
    for (int i = 0; i < n; i++) send_byte(rand_byte());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_filter(input logic [7:0] cls, input logic [7:0] msg);
    cfg_write <= 1'b1;
    cfg_index <= REG_WANTED_CLASS;
    cfg_data <= cls;
    @(posedge clk);
    cfg_index <= REG_WANTED_MESSAGE;
    cfg_data <= msg;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_class = cls;
    cur_msg = msg;
  endtask

  task automatic random_burst();
    int r;
    int len;
    int n;
    logic [7:0] cls;
    logic [7:0] msg;
    in_quiet = ($urandom_range(3, 0) == 0);
    r = $urandom_range(99, 0);
    cls = cur_class;
    msg = cur_msg;
    if (r < 6) cls = cur_class ^ rand_byte(1, 255);
    else if (r < 12) msg = cur_msg ^ rand_byte(1, 255);
    if (r < 85) begin
      len = pick_length();
      send_header(cls, msg, len[15:0]);
      if (r < 12) begin
        n = $urandom_range(3, 0);
        repeat (n) send_byte(rand_byte());
      end else begin
        send_payload(len);
      end
      // checksum pair, never checked
      send_byte(rand_byte());
      send_byte(rand_byte());
    end else if (r < 92) begin
      send_byte(SYNC_FIRST);
      send_byte(rand_byte());
    end else begin
      n = $urandom_range(8, 1);
      repeat (n) send_byte(rand_byte());
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin : stall_gen
      int run;
      run = ($urandom_range(99, 0) < 80) ? $urandom_range(4, 1) : $urandom_range(150, 30);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      run = ($urandom_range(99, 0) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 10);
      out_stall <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int base;
    logic [7:0] cls;
    logic [7:0] msg;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WANTED_CLASS;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    in_quiet = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    cur_class = WANTED_CLASS_RESET;
    cur_msg = WANTED_MESSAGE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty payload, then a short frame with extreme payload bytes
    send_header(cur_class, cur_msg, 16'd0);
    send_header(cur_class, cur_msg, 16'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    // second sync byte wrong and not taken as a new first sync byte
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cur_class);
    send_byte(cur_msg);
    // wrong class, then wrong message
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cur_class ^ 8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cur_class);
    send_byte(cur_msg ^ 8'hFF);

    base = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: begin
            cls = 8'h00;
            msg = 8'h00;
          end
          2: begin
            cls = 8'hFF;
            msg = 8'hFF;
          end
          3: begin
            cls = rand_byte();
            msg = rand_byte();
          end
          default: begin
            cls = SYNC_FIRST;
            msg = SYNC_SECOND;
          end
        endcase
        drain();
        set_filter(cls, msg);
      end
      while (items_sent < base + (p + 1) * RANDOM_ITEMS / PHASES) random_burst();
    end

    // start of a frame of the largest length
    in_quiet = 1'b1;
    send_header(cur_class, cur_msg, 16'hFFFF);
    send_payload(20);
    in_quiet = 1'b0;

    drain();
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
